@@ rtl/sts_pkg.sv @@
// Shared types and constants for the sorted table search unit.
`default_nettype none

package sts_pkg;

   localparam int unsigned DEPTH      = 1024;
   localparam int unsigned ADDR_W     = $clog2(DEPTH);
   localparam int unsigned POS_W      = 11;
   localparam int unsigned KEY_W      = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   // Word index of each control register (byte address bit 2)
   localparam logic REG_ENTRY_COUNT = 1'b0;

   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [KEY_W-1:0]  wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

@@ rtl/sorted_table_binary_search_unit.sv @@
// Top level of the sorted table binary search unit: control register and block wiring.
//
// Usage: the req_ channel carries one item per transfer. A write item (opcode 0)
// stores req_key_value at 1-based req_position in the 1024-entry key table and
// gives no result. Positions of zero or above 1024 are ignored.
// A search item (opcode 1) runs a binary search over positions 1 to entry_count
// and returns on the rsp_ channel the 1-based position of an equal key, or 0.
// Each probe is a key table read in the probe state (single read port, registered
// data) and a compare in the compare state. One item is in work at a time; req_ready
// is high only while the sequencer is idle.
// A finished result sits in an output register; the next item is taken while it
// waits. If the receiver stalls and a second search finishes, the sequencer holds
// that result and accepts nothing more until the output register frees up.
// Reset clears entry_count to 0, empties the output register and idles the
// sequencer; the key table is not cleared and must be written before it is searched.
// Write the entry_count register (byte address 0) over the APB-style port only while
// the block is idle; the block does not check. Values above 1024 are treated as 1024.
`default_nettype none

module sorted_table_binary_search_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [sts_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [sts_pkg::KEY_W-1:0]    req_key_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [sts_pkg::POS_W-1:0]                rsp_found_position,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [sts_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [sts_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);
   import sts_pkg::*;

   logic [POS_W-1:0]        entry_count_ff, entry_count_in;
   logic                    reg_index;
   logic                    csr_write;
   mem_req_type             mem_req;
   logic signed [KEY_W-1:0] mem_rdata;

   // Registers are word-aligned: bit 2 selects the word
   assign reg_index = paddr[2];
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (csr_write && (reg_index == REG_ENTRY_COUNT)) begin
         entry_count_in = pwdata[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Read back the register; unmapped words read as zero
   always_comb begin
      prdata = '0;
      if (reg_index == REG_ENTRY_COUNT) begin
         prdata = CSR_DATA_W'(entry_count_ff);
      end
   end

   sts_search_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_key_value      (req_key_value),
      .entry_count        (entry_count_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found_position (rsp_found_position),
      .mem_req            (mem_req),
      .mem_rdata          (mem_rdata)
   );

   sts_key_mem u_key_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/sts_key_mem.sv @@
// Key table storage: one write port, one read port with registered read data.
`default_nettype none

module sts_key_mem (
   input  wire logic                           clock,
   input  wire sts_pkg::mem_req_type           mem_req,
   output logic signed [sts_pkg::KEY_W-1:0]    rd_data
);
   import sts_pkg::*;

   logic signed [KEY_W-1:0] key_mem [DEPTH];
   logic signed [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= key_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/sts_search_ctrl.sv @@
// Search sequencer: accepts items, issues table writes and probes, holds the result.
`default_nettype none

module sts_search_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_opcode,
   input  wire logic [sts_pkg::POS_W-1:0]      req_position,
   input  wire logic signed [sts_pkg::KEY_W-1:0] req_key_value,
   input  wire logic [sts_pkg::POS_W-1:0]      entry_count,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [sts_pkg::POS_W-1:0]           rsp_found_position,
   output sts_pkg::mem_req_type                mem_req,
   input  wire logic signed [sts_pkg::KEY_W-1:0] mem_rdata
);
   import sts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PROBE = 4'b0010,
      ST_CMP   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [POS_W-1:0]        low_ff, low_in;
   logic [POS_W-1:0]        high_ff, high_in;
   logic [POS_W-1:0]        mid_ff, mid_in;
   logic [POS_W-1:0]        result_ff, result_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   logic [POS_W-1:0]        count_clamped;
   logic [POS_W:0]          mid_sum;
   logic [POS_W-1:0]        mid;
   logic [POS_W-1:0]        mid_less_one;
   logic [POS_W-1:0]        wr_pos_less_one;
   logic                    wr_pos_ok;

   assign count_clamped   = (entry_count > DEPTH_POS) ? DEPTH_POS : entry_count;
   assign mid_sum         = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid             = mid_sum[POS_W:1];
   assign mid_less_one    = mid - POS_W'(1);
   assign wr_pos_less_one = req_position - POS_W'(1);
   assign wr_pos_ok       = (req_position != '0) && (req_position <= DEPTH_POS);

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      result_in    = result_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      mem_req      = '0;

      // drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (opcode_type'(req_opcode) == OP_SEARCH) begin
                  low_in   = POS_W'(1);
                  high_in  = count_clamped;
                  key_in   = req_key_value;
                  state_in = ST_PROBE;
               end else if (wr_pos_ok) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = wr_pos_less_one[ADDR_W-1:0];
                  mem_req.wr_data = req_key_value;
               end
            end
         end
         ST_PROBE: begin
            if (low_ff > high_ff) begin
               result_in = '0;
               state_in  = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid_less_one[ADDR_W-1:0];
               mid_in          = mid;
               state_in        = ST_CMP;
            end
         end
         ST_CMP: begin
            if (mem_rdata == key_ff) begin
               result_in = mid_ff;
               state_in  = ST_DONE;
            end else begin
               if (key_ff < mem_rdata) begin
                  high_in = mid_ff - POS_W'(1);
               end else begin
                  low_in = mid_ff + POS_W'(1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff     <= low_in;
      high_ff    <= high_in;
      mid_ff     <= mid_in;
      result_ff  <= result_in;
      key_ff     <= key_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_position = rsp_pos_ff;

endmodule

`default_nettype wire

@@ test/sorted_table_binary_search_unit_tb.sv @@
// Self-checking testbench for the sorted table binary search unit.
`default_nettype none

// Holds its own copy of the key table and entry count, predicts every search and checks
// each returned position in order.
class search_scoreboard;

   typedef struct {
      logic signed [sts_pkg::KEY_W-1:0] key;
      logic [sts_pkg::POS_W-1:0]        position;
   } lookup_type;

   logic signed [sts_pkg::KEY_W-1:0] key_table [1:sts_pkg::DEPTH];
   bit                               written   [1:sts_pkg::DEPTH];
   logic [sts_pkg::POS_W-1:0]        entry_count = '0;
   lookup_type                       lookups [$];
   int                               mismatches = 0;
   int                               searches_noted = 0;
   int                               writes_noted = 0;

   task report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   function void note_csr_write(input logic [sts_pkg::CSR_ADDR_W-1:0] addr,
                                input logic [sts_pkg::CSR_DATA_W-1:0] data);
      if (addr[2] == sts_pkg::REG_ENTRY_COUNT) begin
         entry_count = data[sts_pkg::POS_W-1:0];
      end
   endfunction

   // Probe the table exactly as the block does: floor midpoint, 1-based positions.
   function logic [sts_pkg::POS_W-1:0] locate_key(input logic signed [sts_pkg::KEY_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 1;
      hi = (entry_count > sts_pkg::DEPTH_POS) ? int'(sts_pkg::DEPTH) : int'(entry_count);
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key_table[mid] == key) begin
            return sts_pkg::POS_W'(mid);
         end
         if (key < key_table[mid]) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return '0;
   endfunction

   function void note_request(input sts_pkg::opcode_type op,
                              input logic [sts_pkg::POS_W-1:0] pos,
                              input logic signed [sts_pkg::KEY_W-1:0] key);
      lookup_type entry;
      if (op == sts_pkg::OP_SEARCH) begin
         entry.key      = key;
         entry.position = locate_key(key);
         lookups.push_back(entry);
         searches_noted++;
      end else begin
         writes_noted++;
         if (pos >= 1 && pos <= sts_pkg::DEPTH_POS) begin
            key_table[pos] = key;
            written[pos]   = 1'b1;
         end
      end
   endfunction

   task check_result(input logic [sts_pkg::POS_W-1:0] got);
      lookup_type entry;
      if (lookups.size() == 0) begin
         report_mismatch($sformatf("found_position %0d with no search outstanding", got));
      end else begin
         entry = lookups.pop_front();
         if (got !== entry.position) begin
            report_mismatch($sformatf("key %0d: found_position %0d, want %0d",
                                      entry.key, got, entry.position));
         end
      end
   endtask

endclass

module sorted_table_binary_search_unit_tb;

   import sts_pkg::*;

   // Cycles to let pass once the last answer is in.
   localparam int SETTLE_CYCLES = 32;
   // Generous ceiling: a few thousand items at worst-case latency and stalls, many times over.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_PERCENT  = 35;
   // Start no new phase once this many items have been transferred; the full-table
   // fill alone goes beyond it.
   localparam int ITEM_BUDGET   = 950;
   // Tables up to this size may get a fresh ascending key run each phase.
   localparam int FRESH_SPAN    = 64;

   localparam logic [CSR_ADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR       = {~REG_ENTRY_COUNT, 2'b00};

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   opcode_type                   req_opcode = OP_WRITE;
   logic [POS_W-1:0]             req_position = '0;
   logic signed [KEY_W-1:0]      req_key_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [POS_W-1:0]             rsp_found_position;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        paddr = '0;
   logic [CSR_DATA_W-1:0]        pwdata = '0;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   search_scoreboard             sb;
   // While set, neither side idles: the long back-to-back stretch.
   bit                           steady = 1'b0;
   int                           cycle_count = 0;
   int                           csr_writes = 0;
   int                           items_sent = 0;
   int                           largest_setting = 0;

   // Keys each phase wants in positions 1..N, and the ascending run for the full table.
   logic signed [KEY_W-1:0]      target_key [1:DEPTH];
   logic signed [KEY_W-1:0]      base_key   [1:DEPTH];

   sorted_table_binary_search_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_key_value      (req_key_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found_position (rsp_found_position),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run; this is the only way out other than the verdict below.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sorted_table_binary_search_unit_tb: FAIL");
         $finish;
      end
   end

   // Receiver: stall at random outside the steady stretch; change only on the falling edge.
   always @(negedge clock) begin
      if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Check every result transfer against the oldest outstanding search.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_found_position);
      end
   end

   // Offer one item and hold it until the transfer completes; valid stays high on return
   // so that back-to-back items follow without a gap.
   task automatic push_item(input opcode_type op, input logic [POS_W-1:0] pos,
                            input logic signed [KEY_W-1:0] key);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_position  <= pos;
      req_key_value <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, pos, key);
      items_sent++;
   endtask

   // Drop valid, wait for every answer, then let a write still in flight finish.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, access cycle, done when pready is seen high.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.note_csr_write(addr, data);
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Fill target_key[1..n] with a random non-decreasing run inside the signed range;
   // zero steps give duplicates, a narrow stride bunches the keys together.
   function automatic void ascending_run(input int n);
      longint unsigned stride;
      longint unsigned slack;
      longint          acc;
      if (n == 0) begin
         return;
      end
      stride = 64'hFFFF_FFFF / longint'(n + 1);
      if ($urandom_range(1) == 1) begin
         stride = longint'($urandom_range(32'(stride)));
      end
      slack = 64'hFFFF_FFFF - longint'(n) * stride;
      acc   = longint'($urandom_range(32'(slack))) - 64'sd2147483648;
      for (int p = 1; p <= n; p++) begin
         acc += longint'($urandom_range(32'(stride)));
         target_key[p] = acc[KEY_W-1:0];
      end
   endfunction

   // One phase: set the entry count while idle, bring positions 1..N to a sorted run,
   // then a random mix of searches, in-order rewrites, corrupting writes and stray writes.
   task automatic run_phase(input int setting);
      int                      span_n;
      int                      items;
      int                      done;
      int                      p;
      int                      r;
      logic signed [KEY_W-1:0] key;
      logic [CSR_DATA_W-1:0]   data;

      settle();
      data = CSR_DATA_W'(setting);
      if ($urandom_range(3) == 0) begin
         // upper bits of the write data lie outside the register: drop them
         data[CSR_DATA_W-1:POS_W] = (CSR_DATA_W-POS_W)'($urandom >> POS_W);
      end
      write_csr(ENTRY_COUNT_ADDR, data);
      if (setting > largest_setting) begin
         largest_setting = setting;
      end

      span_n = (setting > int'(DEPTH)) ? int'(DEPTH) : setting;
      if (span_n <= FRESH_SPAN && $urandom_range(1) == 1) begin
         ascending_run(span_n);
      end else begin
         for (p = 1; p <= span_n; p++) target_key[p] = base_key[p];
      end
      // Restore order, and make sure no probe can land on a position never written.
      for (p = 1; p <= span_n; p++) begin
         if (!sb.written[p] || sb.key_table[p] !== target_key[p]) begin
            push_item(OP_WRITE, POS_W'(p), target_key[p]);
         end
      end

      items = $urandom_range(60, 20);
      done  = 0;
      while (done < items) begin
         r = $urandom_range(99);
         p = (span_n > 0) ? $urandom_range(span_n, 1) : $urandom_range(DEPTH, 1);
         if (r < 60) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: key = (span_n > 0) ? sb.key_table[p] : $urandom;
               5, 6:          key = ((span_n > 0) ? sb.key_table[p] : $urandom)
                                    + (($urandom_range(1) == 1) ? 1 : -1);
               7: begin
                  case ($urandom_range(3))
                     0:       key = KEY_MIN;
                     1:       key = KEY_MAX;
                     2:       key = '0;
                     default: key = -1;
                  endcase
               end
               default:       key = $urandom;
            endcase
            // position is ignored by a search: drive noise on it
            push_item(OP_SEARCH, POS_W'($urandom), key);
            done++;
         end else if (r < 75) begin
            if (span_n > 0) begin
               push_item(OP_WRITE, POS_W'(p), target_key[p]);
            end else begin
               push_item(OP_WRITE, POS_W'(p), $urandom);
            end
            done++;
         end else if (r < 85) begin
            // duplicate the left neighbour (still sorted) or break the order outright
            if (span_n > 0 && p > 1 && $urandom_range(1) == 1) begin
               key = target_key[p - 1];
            end else begin
               key = $urandom;
            end
            push_item(OP_WRITE, POS_W'(p), key);
            done++;
         end else if (r < 92) begin
            // beyond the searched range unless the table is full: such writes must not disturb any answer
            if (span_n < int'(DEPTH)) begin
               p = $urandom_range(DEPTH, span_n + 1);
            end
            push_item(OP_WRITE, POS_W'(p), $urandom);
            done++;
         end else begin
            // position zero or past the table: the block drops it
            p = ($urandom_range(3) == 0) ? 0 : $urandom_range(2047, DEPTH + 1);
            push_item(OP_WRITE, POS_W'(p), $urandom);
         end
      end
   endtask

   // Two small tables first, then the full table with an entry count beyond the depth, then mixed sizes.
   int early_settings [13] = '{1, 8, 2047, 1023, 0, 64, 17, 5, 100, 2, 3, 31, 1024};

   initial begin
      int phase_index;
      int setting;

      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: any search answers zero and reads nothing.
      write_csr(ENTRY_COUNT_ADDR, '0);
      push_item(OP_SEARCH, 11'd2047, '0);
      push_item(OP_SEARCH, 11'd0, KEY_MIN);
      // Writes at position zero or past the table are dropped.
      push_item(OP_WRITE, 11'd0, 32'sd7);
      push_item(OP_WRITE, 11'd1025, 32'sd7);
      push_item(OP_WRITE, 11'd2047, 32'sd7);
      // Five entries covering the key extremes and the sign boundary.
      push_item(OP_WRITE, 11'd1, KEY_MIN);
      push_item(OP_WRITE, 11'd2, -32'sd1);
      push_item(OP_WRITE, 11'd3, 32'sd0);
      push_item(OP_WRITE, 11'd4, 32'sd1);
      push_item(OP_WRITE, 11'd5, KEY_MAX);
      settle();
      write_csr(ENTRY_COUNT_ADDR, 32'd5);
      push_item(OP_SEARCH, 11'd1024, KEY_MIN);
      push_item(OP_SEARCH, 11'd1, KEY_MAX);
      push_item(OP_SEARCH, 11'd0, 32'sd0);
      push_item(OP_SEARCH, 11'd2047, -32'sd1);
      push_item(OP_SEARCH, 11'd5, 32'sd1);
      push_item(OP_SEARCH, 11'd0, 32'sd7);
      push_item(OP_SEARCH, 11'd0, -32'sd2);
      // A write to the unused register word changes nothing.
      settle();
      write_csr(SPARE_ADDR, 32'd1);
      push_item(OP_SEARCH, 11'd0, KEY_MAX);
      // Break the order: the probe path still decides the answer.
      push_item(OP_WRITE, 11'd2, KEY_MAX);
      push_item(OP_SEARCH, 11'd0, -32'sd1);
      push_item(OP_SEARCH, 11'd0, KEY_MAX);
      settle();
      write_csr(ENTRY_COUNT_ADDR, 32'd1);
      push_item(OP_SEARCH, 11'd0, KEY_MIN);

      // Random phases over one ascending run that spans the whole table.
      ascending_run(DEPTH);
      for (int p = 1; p <= int'(DEPTH); p++) base_key[p] = target_key[p];
      phase_index = 0;
      while (items_sent < ITEM_BUDGET) begin
         if (phase_index < 13) begin
            setting = early_settings[phase_index];
         end else if ($urandom_range(15) == 0) begin
            setting = $urandom_range(2047, DEPTH + 1);
         end else if ($urandom_range(7) == 0) begin
            setting = $urandom_range(DEPTH, 49);
         end else begin
            setting = $urandom_range(48, 1);
         end
         steady = (phase_index >= 2 && phase_index <= 4);
         run_phase(setting);
         phase_index++;
      end
      steady = 1'b0;

      settle();
      if (sb.lookups.size() != 0) begin
         sb.report_mismatch($sformatf("%0d searches never answered", sb.lookups.size()));
      end
      $display("run covered %0d searches and %0d table writes under %0d register writes",
               sb.searches_noted, sb.writes_noted, csr_writes);
      $display("entry counts from 0 to %0d, sorted, duplicated, disordered and stray writes",
               largest_setting);
      if (sb.mismatches == 0) begin
         $display("sorted_table_binary_search_unit_tb: PASS");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("sorted_table_binary_search_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sorted_table_binary_search_unit.f @@
rtl/sts_pkg.sv
rtl/sts_key_mem.sv
rtl/sts_search_ctrl.sv
rtl/sorted_table_binary_search_unit.sv
test/sorted_table_binary_search_unit_tb.sv
